// ===== rtl/rsrd_pkg.sv =====
// ----------------------------------------------------------------------------
// rsrd_pkg
// Shared types and constants of the RGBE scanline RLE decoder: register
// codes, stream marker values, the configuration bundle and the descriptor
// that travels from the decode stage to the address stage.
// ----------------------------------------------------------------------------
package rsrd_pkg;

  // Scanline length limits for a line to qualify as per-channel RLE.
  localparam int unsigned MAX_LINE_LENGTH = 32767;
  localparam int unsigned MIN_RLE_LENGTH  = 8;

  // Configuration register indexes.
  localparam logic [2:0] CFG_IMAGE_WIDTH  = 3'd0;
  localparam logic [2:0] CFG_IMAGE_HEIGHT = 3'd1;
  localparam logic [2:0] CFG_COLUMN_ORDER = 3'd2;
  localparam logic [2:0] CFG_REVERSE_X    = 3'd3;
  localparam logic [2:0] CFG_BOTTOM_UP    = 3'd4;

  // Channel select code for a whole-texel write.
  localparam logic [2:0] SEL_TEXEL = 3'd4;

  // Stream marker values.
  localparam logic [7:0] HDR_MARK      = 8'd2;
  localparam logic [7:0] OLD_REP_MARK  = 8'd1;
  localparam logic [7:0] RUN_THRESHOLD = 8'd128;

  // Old-RLE repeat shift grows by one byte per repeat texel, up to 24.
  localparam logic [4:0] SHIFT_STEP = 5'd8;
  localparam logic [4:0] SHIFT_MAX  = 5'd24;

  // Configuration registers as one bundle.
  typedef struct packed {
    logic [14:0] image_width;
    logic [14:0] image_height;
    logic        column_order;
    logic        reverse_x;
    logic        bottom_up;
  } cfg_t;

  // Decoded write descriptor with the destination texel position.
  typedef struct packed {
    logic [2:0]  channel_sel;
    logic [31:0] texel;
    logic [14:0] pos_x;
    logic [14:0] pos_y;
    logic [14:0] run_count;
    logic        line_done;
    logic        image_done;
    logic        overrun;
  } desc_t;

  // A zero image dimension is treated as one.
  function automatic logic [14:0] eff_dim(input logic [14:0] d);
    return (d == 15'd0) ? 15'd1 : d;
  endfunction

endpackage

// ===== rtl/rgbe_scanline_rle_decoder.sv =====
// ----------------------------------------------------------------------------
// rgbe_scanline_rle_decoder
// Decodes the pixel section of an RGBE picture, one byte per word, into
// write descriptors for the destination texel image.
// ----------------------------------------------------------------------------
// The decoder takes one compressed byte per clock cycle, every cycle, as long
// as the consumer keeps up. A byte that completes a write is captured in the
// decode register (scanline state update and texel position) when it is
// accepted, then moves on to the output register, where a 15 by 15 bit
// multiply forms the destination byte offset and its descriptor is offered;
// a stall from the consumer can hold it in the decode register in between.
// The stall path from out_ready to in_ready passes through both stages.
// Writing a known configuration register restarts decoding at the first
// scanline; registers are to be written only while the decoder is idle.
// Once the last scanline completes, further bytes are accepted and dropped.
module rgbe_scanline_rle_decoder
  import rsrd_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_wr_en,
  input  logic [2:0]         cfg_index,
  input  logic [14:0]        cfg_wdata,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         in_data_byte,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [2:0]         out_channel_sel,
  output logic [7:0]         out_byte_r,
  output logic [7:0]         out_byte_g,
  output logic [7:0]         out_byte_b,
  output logic [7:0]         out_byte_e,
  output logic [31:0]        out_dest_offset,
  output logic signed [17:0] out_dest_step,
  output logic [14:0]        out_run_count,
  output logic               out_line_done,
  output logic               out_image_done,
  output logic               out_overrun
);

  cfg_t  cfg_r, cfg_nxt;
  logic  restart;
  logic  desc_valid;
  logic  desc_ready;
  desc_t desc;

  // Register write decode; an unknown index changes nothing.
  always_comb begin
    cfg_nxt = cfg_r;
    restart = 1'b0;
    if (cfg_wr_en) begin
      case (cfg_index)
        CFG_IMAGE_WIDTH: begin
          cfg_nxt.image_width = cfg_wdata;
          restart             = 1'b1;
        end
        CFG_IMAGE_HEIGHT: begin
          cfg_nxt.image_height = cfg_wdata;
          restart              = 1'b1;
        end
        CFG_COLUMN_ORDER: begin
          cfg_nxt.column_order = cfg_wdata[0];
          restart              = 1'b1;
        end
        CFG_REVERSE_X: begin
          cfg_nxt.reverse_x = cfg_wdata[0];
          restart           = 1'b1;
        end
        CFG_BOTTOM_UP: begin
          cfg_nxt.bottom_up = cfg_wdata[0];
          restart           = 1'b1;
        end
        default: ;
      endcase
    end
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.image_width  <= 15'd1;
      cfg_r.image_height <= 15'd1;
      cfg_r.column_order <= 1'b0;
      cfg_r.reverse_x    <= 1'b0;
      cfg_r.bottom_up    <= 1'b0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  rsrd_decode u_decode (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg          (cfg_r),
    .restart      (restart),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_data_byte (in_data_byte),
    .desc_valid   (desc_valid),
    .desc_ready   (desc_ready),
    .desc         (desc)
  );

  rsrd_addr u_addr (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg             (cfg_r),
    .desc_valid      (desc_valid),
    .desc_ready      (desc_ready),
    .desc            (desc),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_channel_sel (out_channel_sel),
    .out_byte_r      (out_byte_r),
    .out_byte_g      (out_byte_g),
    .out_byte_b      (out_byte_b),
    .out_byte_e      (out_byte_e),
    .out_dest_offset (out_dest_offset),
    .out_dest_step   (out_dest_step),
    .out_run_count   (out_run_count),
    .out_line_done   (out_line_done),
    .out_image_done  (out_image_done),
    .out_overrun     (out_overrun)
  );

endmodule

// ===== rtl/rsrd_decode.sv =====
// ----------------------------------------------------------------------------
// rsrd_decode
// Byte-serial scanline decoder. Tracks header check, old per-texel RLE and
// per-channel adaptive RLE, and registers one write descriptor per byte
// that completes a write.
// ----------------------------------------------------------------------------
module rsrd_decode
  import rsrd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  cfg_t        cfg,
  input  logic        restart,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_data_byte,
  output logic        desc_valid,
  input  logic        desc_ready,
  output desc_t       desc
);

  typedef enum logic [1:0] {
    MODE_HEADER,
    MODE_OLD,
    MODE_CHAN
  } mode_t;

  mode_t       line_mode_r, line_mode_nxt;
  logic [7:0]  hdr0_r, hdr0_nxt;
  logic [7:0]  hdr1_r, hdr1_nxt;
  logic [7:0]  hdr2_r, hdr2_nxt;
  logic [1:0]  byte_phase_r, byte_phase_nxt;
  logic [14:0] scanline_count_r, scanline_count_nxt;
  logic [14:0] texel_count_r, texel_count_nxt;
  logic [1:0]  channel_index_r, channel_index_nxt;
  logic [7:0]  run_remaining_r, run_remaining_nxt;
  logic        run_is_repeat_r, run_is_repeat_nxt;
  logic        lit_clip_r, lit_clip_nxt;
  logic [31:0] last_texel_r, last_texel_nxt;
  logic [23:0] partial_texel_r, partial_texel_nxt;
  logic [4:0]  repeat_shift_r, repeat_shift_nxt;
  logic        image_finished_r, image_finished_nxt;

  logic        desc_valid_r;
  desc_t       desc_r, desc_nxt;

  logic        accept;
  logic        emit;
  logic [14:0] eff_w;
  logic [14:0] eff_h;
  logic [14:0] line_len;
  logic [14:0] num_lines;
  logic [14:0] rem;
  logic        hdr_ok;

  // Geometry of the scanlines under the current configuration.
  assign eff_w     = eff_dim(cfg.image_width);
  assign eff_h     = eff_dim(cfg.image_height);
  assign line_len  = cfg.column_order ? eff_h : eff_w;
  assign num_lines = cfg.column_order ? eff_w : eff_h;
  assign rem       = line_len - texel_count_r;

  // A new byte enters whenever the descriptor slot is free or drains.
  assign in_ready   = !desc_valid_r || desc_ready;
  assign accept     = in_valid && in_ready;
  assign desc_valid = desc_valid_r;
  assign desc       = desc_r;

  // Header test on the three stored bytes and the current one.
  assign hdr_ok = (hdr0_r == HDR_MARK) && (hdr1_r == HDR_MARK) && !hdr2_r[7] &&
                  ({hdr2_r[6:0], in_data_byte} == line_len) &&
                  (line_len >= 15'(MIN_RLE_LENGTH)) &&
                  (line_len <= 15'(MAX_LINE_LENGTH));

  // Next-state logic for one byte.
  always_comb begin
    logic        old_go;
    logic [31:0] old_texel;
    logic [31:0] rep_cnt;
    logic [2:0]  em_sel;
    logic [31:0] em_texel;
    logic [14:0] em_cnt;
    logic        em_clip;
    logic        em_whole;
    logic        em_done;
    logic        em_img;
    logic [15:0] tc_sum;
    logic [15:0] scan_sum;
    logic [14:0] tpos;

    line_mode_nxt      = line_mode_r;
    hdr0_nxt           = hdr0_r;
    hdr1_nxt           = hdr1_r;
    hdr2_nxt           = hdr2_r;
    byte_phase_nxt     = byte_phase_r;
    scanline_count_nxt = scanline_count_r;
    texel_count_nxt    = texel_count_r;
    channel_index_nxt  = channel_index_r;
    run_remaining_nxt  = run_remaining_r;
    run_is_repeat_nxt  = run_is_repeat_r;
    lit_clip_nxt       = lit_clip_r;
    last_texel_nxt     = last_texel_r;
    partial_texel_nxt  = partial_texel_r;
    repeat_shift_nxt   = repeat_shift_r;
    image_finished_nxt = image_finished_r;

    old_go    = 1'b0;
    old_texel = '0;
    rep_cnt   = '0;
    emit      = 1'b0;
    em_sel    = SEL_TEXEL;
    em_texel  = '0;
    em_cnt    = 15'd1;
    em_clip   = 1'b0;
    em_whole  = 1'b1;
    em_done   = 1'b0;
    em_img    = 1'b0;
    tc_sum    = '0;
    scan_sum  = '0;
    tpos      = texel_count_r;

    if (accept && !image_finished_r) begin
      case (line_mode_r)
        MODE_HEADER: begin
          if (byte_phase_r != 2'd3) begin
            case (byte_phase_r)
              2'd0:    hdr0_nxt = in_data_byte;
              2'd1:    hdr1_nxt = in_data_byte;
              default: hdr2_nxt = in_data_byte;
            endcase
            byte_phase_nxt = byte_phase_r + 2'd1;
          end else begin
            byte_phase_nxt = 2'd0;
            if (hdr_ok) begin
              line_mode_nxt     = MODE_CHAN;
              channel_index_nxt = 2'd0;
              texel_count_nxt   = 15'd0;
              run_remaining_nxt = 8'd0;
              run_is_repeat_nxt = 1'b0;
              lit_clip_nxt      = 1'b0;
            end else begin
              line_mode_nxt = MODE_OLD;
              old_go        = 1'b1;
              old_texel     = {hdr0_r, hdr1_r, hdr2_r, in_data_byte};
            end
          end
        end
        MODE_OLD: begin
          if (byte_phase_r != 2'd3) begin
            partial_texel_nxt = {partial_texel_r[15:0], in_data_byte};
            byte_phase_nxt    = byte_phase_r + 2'd1;
          end else begin
            byte_phase_nxt = 2'd0;
            old_go         = 1'b1;
            old_texel      = {partial_texel_r, in_data_byte};
          end
        end
        MODE_CHAN: begin
          em_whole = 1'b0;
          em_sel   = {1'b0, channel_index_r};
          em_texel = {in_data_byte, 24'd0};
          if (run_remaining_r == 8'd0) begin
            // Control byte: a repeat run above the threshold, else literals.
            if (in_data_byte > RUN_THRESHOLD) begin
              run_is_repeat_nxt = 1'b1;
              run_remaining_nxt = {1'b0, in_data_byte[6:0]};
              lit_clip_nxt      = 1'b0;
            end else begin
              run_is_repeat_nxt = 1'b0;
              lit_clip_nxt      = {7'd0, in_data_byte} > rem;
              run_remaining_nxt = ({7'd0, in_data_byte} > rem) ? rem[7:0] : in_data_byte;
            end
          end else if (run_is_repeat_r) begin
            emit              = 1'b1;
            run_remaining_nxt = 8'd0;
            if ({7'd0, run_remaining_r} > rem) begin
              em_cnt  = rem;
              em_clip = 1'b1;
            end else begin
              em_cnt = {7'd0, run_remaining_r};
            end
          end else begin
            emit              = 1'b1;
            run_remaining_nxt = run_remaining_r - 8'd1;
            em_cnt            = 15'd1;
            em_clip           = lit_clip_r && (run_remaining_r == 8'd1);
            if (run_remaining_r == 8'd1) begin
              lit_clip_nxt = 1'b0;
            end
          end
        end
        default: ;
      endcase

      // Old-RLE texel: either a repeat marker or a new literal texel.
      if (old_go) begin
        if (old_texel[31:8] == {OLD_REP_MARK, OLD_REP_MARK, OLD_REP_MARK}) begin
          rep_cnt = {24'd0, old_texel[7:0]} << repeat_shift_r;
          if (repeat_shift_r < SHIFT_MAX) begin
            repeat_shift_nxt = repeat_shift_r + SHIFT_STEP;
          end
          if (old_texel[7:0] != 8'd0) begin
            emit     = 1'b1;
            em_texel = last_texel_r;
            if (rep_cnt > {17'd0, rem}) begin
              em_cnt  = rem;
              em_clip = 1'b1;
            end else begin
              em_cnt = rep_cnt[14:0];
            end
          end
        end else begin
          last_texel_nxt   = old_texel;
          repeat_shift_nxt = 5'd0;
          emit             = 1'b1;
          em_texel         = old_texel;
          em_cnt           = 15'd1;
        end
      end

      // Advance the position and close the channel or the scanline.
      if (emit) begin
        tc_sum          = {1'b0, texel_count_r} + {1'b0, em_cnt};
        texel_count_nxt = tc_sum[14:0];
        if (tc_sum >= {1'b0, line_len}) begin
          if (em_whole || (channel_index_r == 2'd3)) begin
            em_done            = 1'b1;
            scan_sum           = {1'b0, scanline_count_r} + 16'd1;
            scanline_count_nxt = scan_sum[14:0];
            texel_count_nxt    = 15'd0;
            channel_index_nxt  = 2'd0;
            run_remaining_nxt  = 8'd0;
            run_is_repeat_nxt  = 1'b0;
            lit_clip_nxt       = 1'b0;
            line_mode_nxt      = MODE_HEADER;
            byte_phase_nxt     = 2'd0;
            last_texel_nxt     = '0;
            repeat_shift_nxt   = 5'd0;
            if (scan_sum >= {1'b0, num_lines}) begin
              image_finished_nxt = 1'b1;
              em_img             = 1'b1;
            end
          end else begin
            channel_index_nxt = channel_index_r + 2'd1;
            texel_count_nxt   = 15'd0;
          end
        end
      end
    end

    // Descriptor: source position mapped to destination x and y.
    desc_nxt.channel_sel = em_sel;
    desc_nxt.texel       = em_texel;
    desc_nxt.run_count   = em_cnt;
    desc_nxt.line_done   = em_done;
    desc_nxt.image_done  = em_img;
    desc_nxt.overrun     = em_clip;
    if (cfg.column_order) begin
      desc_nxt.pos_x = cfg.reverse_x ? (eff_w - 15'd1 - scanline_count_r) : scanline_count_r;
      desc_nxt.pos_y = cfg.bottom_up ? (eff_h - 15'd1 - tpos) : tpos;
    end else begin
      desc_nxt.pos_x = cfg.reverse_x ? (eff_w - 15'd1 - tpos) : tpos;
      desc_nxt.pos_y = cfg.bottom_up ? (eff_h - 15'd1 - scanline_count_r) : scanline_count_r;
    end

    // A write to a known register index starts the picture over.
    if (restart) begin
      line_mode_nxt      = MODE_HEADER;
      hdr0_nxt           = '0;
      hdr1_nxt           = '0;
      hdr2_nxt           = '0;
      byte_phase_nxt     = 2'd0;
      scanline_count_nxt = '0;
      texel_count_nxt    = '0;
      channel_index_nxt  = 2'd0;
      run_remaining_nxt  = '0;
      run_is_repeat_nxt  = 1'b0;
      lit_clip_nxt       = 1'b0;
      last_texel_nxt     = '0;
      partial_texel_nxt  = '0;
      repeat_shift_nxt   = '0;
      image_finished_nxt = 1'b0;
      emit               = 1'b0;
    end
  end

  // Decoder state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_mode_r      <= MODE_HEADER;
      hdr0_r           <= '0;
      hdr1_r           <= '0;
      hdr2_r           <= '0;
      byte_phase_r     <= 2'd0;
      scanline_count_r <= '0;
      texel_count_r    <= '0;
      channel_index_r  <= 2'd0;
      run_remaining_r  <= '0;
      run_is_repeat_r  <= 1'b0;
      lit_clip_r       <= 1'b0;
      last_texel_r     <= '0;
      partial_texel_r  <= '0;
      repeat_shift_r   <= '0;
      image_finished_r <= 1'b0;
      desc_valid_r     <= 1'b0;
    end else begin
      line_mode_r      <= line_mode_nxt;
      hdr0_r           <= hdr0_nxt;
      hdr1_r           <= hdr1_nxt;
      hdr2_r           <= hdr2_nxt;
      byte_phase_r     <= byte_phase_nxt;
      scanline_count_r <= scanline_count_nxt;
      texel_count_r    <= texel_count_nxt;
      channel_index_r  <= channel_index_nxt;
      run_remaining_r  <= run_remaining_nxt;
      run_is_repeat_r  <= run_is_repeat_nxt;
      lit_clip_r       <= lit_clip_nxt;
      last_texel_r     <= last_texel_nxt;
      partial_texel_r  <= partial_texel_nxt;
      repeat_shift_r   <= repeat_shift_nxt;
      image_finished_r <= image_finished_nxt;
      if (in_ready) begin
        desc_valid_r <= accept && emit;
      end
    end
  end

  // Descriptor payload.
  always_ff @(posedge clk) begin
    if (accept && emit) begin
      desc_r <= desc_nxt;
    end
  end

  // The position inside a scanline never reaches the line length.
  assert property (@(posedge clk) disable iff (!rst_n) texel_count_r < line_len)
    else $error("texel position past the line length");

  // Only per-channel lines move past the red channel or hold a pending run.
  assert property (@(posedge clk) disable iff (!rst_n)
    (channel_index_r != 2'd0 || run_remaining_r != 8'd0) |-> line_mode_r == MODE_CHAN)
    else $error("channel state outside a per-channel line");

  // The last scanline's write also closes its line.
  assert property (@(posedge clk) disable iff (!rst_n)
    (desc_valid_r && desc_r.image_done) |-> desc_r.line_done)
    else $error("image done without line done");

  // Bytes after the end of the picture produce nothing.
  assert property (@(posedge clk) disable iff (!rst_n)
    (accept && image_finished_r) |=> !desc_valid_r)
    else $error("write produced after the picture finished");

endmodule

// ===== rtl/rsrd_addr.sv =====
// ----------------------------------------------------------------------------
// rsrd_addr
// Output stage: turns a descriptor's destination x and y into a byte offset,
// attaches the signed texel stride and holds the finished word for the consumer.
// ----------------------------------------------------------------------------
module rsrd_addr
  import rsrd_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  cfg_t               cfg,
  input  logic               desc_valid,
  output logic               desc_ready,
  input  desc_t              desc,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [2:0]         out_channel_sel,
  output logic [7:0]         out_byte_r,
  output logic [7:0]         out_byte_g,
  output logic [7:0]         out_byte_b,
  output logic [7:0]         out_byte_e,
  output logic [31:0]        out_dest_offset,
  output logic signed [17:0] out_dest_step,
  output logic [14:0]        out_run_count,
  output logic               out_line_done,
  output logic               out_image_done,
  output logic               out_overrun
);

  logic [14:0] eff_w;
  logic [29:0] row_base;
  logic [30:0] lin_index;
  logic [31:0] offset_nxt;
  logic [16:0] step_mag;
  logic        step_neg;
  logic [17:0] step_nxt;
  logic        out_valid_r;
  logic [31:0] offset_r;
  logic [17:0] step_r;
  desc_t       word_r;

  assign eff_w = eff_dim(cfg.image_width);

  // Byte offset: (y * width + x) * 4, kept to 32 bits.
  assign row_base   = desc.pos_y * eff_w;
  assign lin_index  = {1'b0, row_base} + {16'd0, desc.pos_x};
  assign offset_nxt = {lin_index[29:0], 2'b00};

  // Stride: one texel along a row, one row along a column.
  assign step_mag = cfg.column_order ? {eff_w, 2'b00} : 17'd4;
  assign step_neg = cfg.column_order ? cfg.bottom_up : cfg.reverse_x;
  assign step_nxt = step_neg ? (18'd0 - {1'b0, step_mag}) : {1'b0, step_mag};

  assign desc_ready = !out_valid_r || out_ready;

  // Output word valid flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (desc_ready) begin
      out_valid_r <= desc_valid;
    end
  end

  // Output word payload.
  always_ff @(posedge clk) begin
    if (desc_ready && desc_valid) begin
      word_r   <= desc;
      offset_r <= offset_nxt;
      step_r   <= step_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_channel_sel = word_r.channel_sel;
  assign out_byte_r      = word_r.texel[31:24];
  assign out_byte_g      = word_r.texel[23:16];
  assign out_byte_b      = word_r.texel[15:8];
  assign out_byte_e      = word_r.texel[7:0];
  assign out_dest_offset = offset_r;
  assign out_dest_step   = $signed(step_r);
  assign out_run_count   = word_r.run_count;
  assign out_line_done   = word_r.line_done;
  assign out_image_done  = word_r.image_done;
  assign out_overrun     = word_r.overrun;

endmodule

// ===== sim/rgbe_scanline_rle_decoder_test.sv =====
// ----------------------------------------------------------------------------
// rgbe_scanline_rle_decoder_test
// Self-checking testbench for the RGBE scanline RLE decoder. Byte streams are
// built as whole images of adaptive RLE lines, old per-texel RLE lines,
// broken headers and plain noise, under many image geometries. A local
// decoder model predicts every write descriptor as each byte word is
// accepted, and a monitor checks each descriptor against the oldest
// prediction, with random idling on both handshakes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rgbe_scanline_rle_decoder_test;
  import rsrd_pkg::*;

  // Scanline decode modes of the model.
  typedef enum logic [1:0] {
    SCAN_HEADER,
    SCAN_OLD,
    SCAN_CHAN
  } scan_mode_t;

  // One expected write descriptor.
  typedef struct packed {
    logic [2:0]  sel;
    logic [7:0]  r;
    logic [7:0]  g;
    logic [7:0]  b;
    logic [7:0]  e;
    logic [31:0] offset;
    logic [17:0] stride;
    logic [14:0] count;
    logic        line_done;
    logic        image_done;
    logic        overrun;
  } write_desc_t;

  localparam int unsigned STIM_BYTES  = 1450;
  localparam int unsigned QUIET_FROM  = 1150;
  localparam int unsigned LONG_HOLD   = 150;
  localparam int unsigned DRAIN_GUARD = 20000;
  localparam int unsigned SETTLE      = 6;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               cfg_wr_en = 1'b0;
  logic [2:0]         cfg_index = CFG_IMAGE_WIDTH;
  logic [14:0]        cfg_wdata = 15'd0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [7:0]         in_data_byte = 8'd0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [2:0]         out_channel_sel;
  logic [7:0]         out_byte_r;
  logic [7:0]         out_byte_g;
  logic [7:0]         out_byte_b;
  logic [7:0]         out_byte_e;
  logic [31:0]        out_dest_offset;
  logic signed [17:0] out_dest_step;
  logic [14:0]        out_run_count;
  logic               out_line_done;
  logic               out_image_done;
  logic               out_overrun;

  rgbe_scanline_rle_decoder uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_data_byte    (in_data_byte),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_channel_sel (out_channel_sel),
    .out_byte_r      (out_byte_r),
    .out_byte_g      (out_byte_g),
    .out_byte_b      (out_byte_b),
    .out_byte_e      (out_byte_e),
    .out_dest_offset (out_dest_offset),
    .out_dest_step   (out_dest_step),
    .out_run_count   (out_run_count),
    .out_line_done   (out_line_done),
    .out_image_done  (out_image_done),
    .out_overrun     (out_overrun)
  );

  always #5 clk = ~clk;

  // Stimulus and bookkeeping.
  logic [7:0]  byte_feed [$];
  write_desc_t expected_writes [$];
  int unsigned pushed_count = 0;
  int unsigned accepted_count = 0;
  int unsigned stim_total = 0;
  int unsigned mismatch_count = 0;
  bit          in_taken = 1'b0;
  bit          quiet = 1'b0;
  bit          sender_idling = 1'b1;
  bit          receiver_idling = 1'b1;
  bit          long_hold_req = 1'b0;
  bit          pause_done = 1'b0;
  int unsigned send_gap = 0;
  int unsigned stall_left = 0;
  int unsigned hold_left = 0;

  // Model copy of the registers.
  logic [14:0] reg_width;
  logic [14:0] reg_height;
  logic        reg_col;
  logic        reg_revx;
  logic        reg_bup;

  // Model copy of the scanline state.
  scan_mode_t  scan_mode;
  logic [7:0]  hdr_byte [0:2];
  int unsigned phase_idx;
  int unsigned line_no;
  int unsigned texel_no;
  int unsigned chan_no;
  int unsigned run_left;
  bit          run_repeat;
  bit          lit_clipped;
  logic [31:0] prev_texel;
  logic [23:0] texel_bytes;
  int unsigned rep_shift;
  bit          image_over;

  function automatic int unsigned width_eff();
    return (reg_width == 15'd0) ? 1 : int'(reg_width);
  endfunction

  function automatic int unsigned height_eff();
    return (reg_height == 15'd0) ? 1 : int'(reg_height);
  endfunction

  function automatic int unsigned lines_total();
    return reg_col ? width_eff() : height_eff();
  endfunction

  function automatic int unsigned line_length();
    return reg_col ? height_eff() : width_eff();
  endfunction

  // Byte offset of texel t of the current scanline in the row-major image.
  function automatic logic [31:0] dest_byte_offset(input int unsigned t);
    longint unsigned w, h, x, y;
    w = width_eff();
    h = height_eff();
    if (reg_col) begin
      x = reg_revx ? w - 1 - line_no : line_no;
      y = reg_bup ? h - 1 - t : t;
    end else begin
      x = reg_revx ? w - 1 - t : t;
      y = reg_bup ? h - 1 - line_no : line_no;
    end
    return 32'((y * w + x) * 4);
  endfunction

  // Signed stride between texels along a scanline.
  function automatic logic [17:0] dest_stride();
    logic [17:0] mag;
    bit          neg;
    if (reg_col) begin
      mag = 18'(4 * width_eff());
      neg = reg_bup;
    end else begin
      mag = 18'd4;
      neg = reg_revx;
    end
    return neg ? 18'd0 - mag : mag;
  endfunction

  task automatic clear_scan_state();
    scan_mode = SCAN_HEADER;
    hdr_byte[0] = 8'd0;
    hdr_byte[1] = 8'd0;
    hdr_byte[2] = 8'd0;
    phase_idx = 0;
    line_no = 0;
    texel_no = 0;
    chan_no = 0;
    run_left = 0;
    run_repeat = 1'b0;
    lit_clipped = 1'b0;
    prev_texel = 32'd0;
    texel_bytes = 24'd0;
    rep_shift = 0;
    image_over = 1'b0;
  endtask

  task automatic apply_register(input logic [2:0] idx, input logic [14:0] value);
    bit known;
    known = 1'b1;
    case (idx)
      CFG_IMAGE_WIDTH: reg_width = value;
      CFG_IMAGE_HEIGHT: reg_height = value;
      CFG_COLUMN_ORDER: reg_col = value[0];
      CFG_REVERSE_X: reg_revx = value[0];
      CFG_BOTTOM_UP: reg_bup = value[0];
      default: known = 1'b0;
    endcase
    if (known) clear_scan_state();
  endtask

  // Closes the scanline; last is set when it was the final one.
  task automatic finish_line(output bit last);
    line_no++;
    texel_no = 0;
    chan_no = 0;
    run_left = 0;
    run_repeat = 1'b0;
    lit_clipped = 1'b0;
    scan_mode = SCAN_HEADER;
    phase_idx = 0;
    prev_texel = 32'd0;
    rep_shift = 0;
    last = (line_no >= lines_total());
    if (last) image_over = 1'b1;
  endtask

  // Records one write starting at the current texel and moves past it.
  task automatic queue_write(input logic [2:0] sel, input logic [31:0] value,
                             input int unsigned cnt, input bit clipped,
                             input bit texel_line);
    write_desc_t d;
    bit          last;
    d.sel = sel;
    if (sel == SEL_TEXEL) begin
      {d.r, d.g, d.b, d.e} = value;
    end else begin
      d.r = value[7:0];
      d.g = 8'd0;
      d.b = 8'd0;
      d.e = 8'd0;
    end
    d.offset = dest_byte_offset(texel_no);
    d.stride = dest_stride();
    d.count = cnt[14:0];
    d.line_done = 1'b0;
    d.image_done = 1'b0;
    d.overrun = clipped;
    texel_no += cnt;
    if (texel_no >= line_length()) begin
      if (texel_line || chan_no >= 3) begin
        d.line_done = 1'b1;
        finish_line(last);
        d.image_done = last;
      end else begin
        chan_no++;
        texel_no = 0;
      end
    end
    expected_writes.push_back(d);
  endtask

  // One old-RLE texel: either a literal texel or a repeat of the last one.
  task automatic old_rle_texel(input logic [7:0] r, input logic [7:0] g,
                               input logic [7:0] b, input logic [7:0] e);
    int unsigned     rem;
    longint unsigned cnt;
    bit              clipped;
    rem = line_length() - texel_no;
    if (r == OLD_REP_MARK && g == OLD_REP_MARK && b == OLD_REP_MARK) begin
      cnt = 64'(e) << rep_shift;
      clipped = 1'b0;
      if (rep_shift < SHIFT_MAX) rep_shift += SHIFT_STEP;
      if (cnt != 0) begin
        if (cnt > rem) begin
          cnt = rem;
          clipped = 1'b1;
        end
        queue_write(SEL_TEXEL, prev_texel, int'(cnt), clipped, 1'b1);
      end
    end else begin
      prev_texel = {r, g, b, e};
      rep_shift = 0;
      queue_write(SEL_TEXEL, prev_texel, 1, 1'b0, 1'b1);
    end
  endtask

  // One byte of a per-channel adaptive RLE line.
  task automatic channel_rle_byte(input logic [7:0] v);
    int unsigned rem, cnt;
    bit          clipped;
    rem = line_length() - texel_no;
    if (run_left == 0) begin
      if (v > RUN_THRESHOLD) begin
        run_repeat = 1'b1;
        run_left = v & 8'h7F;
        lit_clipped = 1'b0;
      end else begin
        run_repeat = 1'b0;
        lit_clipped = (v > rem);
        run_left = lit_clipped ? rem : v;
      end
    end else if (run_repeat) begin
      cnt = run_left;
      clipped = 1'b0;
      if (cnt > rem) begin
        cnt = rem;
        clipped = 1'b1;
      end
      run_left = 0;
      queue_write(3'(chan_no), {24'd0, v}, cnt, clipped, 1'b0);
    end else begin
      run_left--;
      clipped = lit_clipped && (run_left == 0);
      if (run_left == 0) lit_clipped = 1'b0;
      queue_write(3'(chan_no), {24'd0, v}, 1, clipped, 1'b0);
    end
  endtask

  // Predicts the descriptor, if any, that one accepted byte word causes.
  task automatic decode_byte(input logic [7:0] v);
    int unsigned len, hl;
    if (!image_over) begin
      case (scan_mode)
        SCAN_HEADER: begin
          if (phase_idx < 3) begin
            hdr_byte[phase_idx] = v;
            phase_idx++;
          end else begin
            phase_idx = 0;
            len = line_length();
            hl = {hdr_byte[2][6:0], v};
            if (hdr_byte[0] == HDR_MARK && hdr_byte[1] == HDR_MARK && !hdr_byte[2][7] &&
                hl == len && len >= MIN_RLE_LENGTH && len <= MAX_LINE_LENGTH) begin
              scan_mode = SCAN_CHAN;
              chan_no = 0;
              texel_no = 0;
              run_left = 0;
              run_repeat = 1'b0;
              lit_clipped = 1'b0;
            end else begin
              scan_mode = SCAN_OLD;
              old_rle_texel(hdr_byte[0], hdr_byte[1], hdr_byte[2], v);
            end
          end
        end
        SCAN_OLD: begin
          if (phase_idx < 3) begin
            texel_bytes = {texel_bytes[15:0], v};
            phase_idx++;
          end else begin
            phase_idx = 0;
            old_rle_texel(texel_bytes[23:16], texel_bytes[15:8], texel_bytes[7:0], v);
          end
        end
        SCAN_CHAN: channel_rle_byte(v);
        default: ;
      endcase
    end
  endtask

  // Counts each mismatch and prints one line for each of the first 40.
  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    mismatch_count++;
    if (mismatch_count <= 40)
      $display("%0t: mismatch on %s: got 0x%0h, want 0x%0h", $realtime, what, got, want);
  endtask

  task automatic check_write();
    write_desc_t want;
    if (expected_writes.size() == 0) begin
      report_mismatch("descriptor with none expected, offset", out_dest_offset, 32'd0);
    end else begin
      want = expected_writes.pop_front();
      if (out_channel_sel !== want.sel)
        report_mismatch("channel_sel", 32'(out_channel_sel), 32'(want.sel));
      if (out_byte_r !== want.r) report_mismatch("byte_r", 32'(out_byte_r), 32'(want.r));
      if (out_byte_g !== want.g) report_mismatch("byte_g", 32'(out_byte_g), 32'(want.g));
      if (out_byte_b !== want.b) report_mismatch("byte_b", 32'(out_byte_b), 32'(want.b));
      if (out_byte_e !== want.e) report_mismatch("byte_e", 32'(out_byte_e), 32'(want.e));
      if (out_dest_offset !== want.offset)
        report_mismatch("dest_offset", out_dest_offset, want.offset);
      if (out_dest_step !== want.stride)
        report_mismatch("dest_step", 32'(unsigned'(out_dest_step)), 32'(want.stride));
      if (out_run_count !== want.count)
        report_mismatch("run_count", 32'(out_run_count), 32'(want.count));
      if (out_line_done !== want.line_done)
        report_mismatch("line_done", 32'(out_line_done), 32'(want.line_done));
      if (out_image_done !== want.image_done)
        report_mismatch("image_done", 32'(out_image_done), 32'(want.image_done));
      if (out_overrun !== want.overrun)
        report_mismatch("overrun", 32'(out_overrun), 32'(want.overrun));
    end
  endtask

  // Sample both handshakes and the configuration port at the rising edge.
  always @(posedge clk) begin
    in_taken = in_valid && in_ready;
    if (rst_n) begin
      if (cfg_wr_en) apply_register(cfg_index, cfg_wdata);
      if (in_taken) begin
        accepted_count++;
        decode_byte(in_data_byte);
      end
      if ($isunknown(out_valid)) report_mismatch("out_valid unknown", 32'd0, 32'd0);
      else if (out_valid && out_ready) check_write();
    end
  end

  // Sender: offers the next byte word once the last one is taken.
  always @(negedge clk) begin
    if (!in_valid || in_taken) begin
      if (send_gap > 0) begin
        send_gap--;
        in_valid <= 1'b0;
      end else if (byte_feed.size() > 0) begin
        in_data_byte <= byte_feed.pop_front();
        in_valid <= 1'b1;
        if (!quiet && sender_idling && $urandom_range(0, 5) == 0)
          send_gap = $urandom_range(1, 3);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: short random stalls, plus one long hold-off on request.
  always @(negedge clk) begin
    if (long_hold_req) begin
      long_hold_req = 1'b0;
      hold_left = LONG_HOLD;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (!quiet && receiver_idling && stall_left > 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else if (!quiet && receiver_idling && $urandom_range(0, 6) == 0) begin
      stall_left = $urandom_range(0, 2);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  task automatic push_byte(input logic [7:0] b, input bit counted);
    byte_feed.push_back(b);
    pushed_count++;
    if (counted) stim_total++;
  endtask

  task automatic push_random(input int unsigned n);
    repeat (n) push_byte(8'($urandom_range(0, 255)), 1'b1);
  endtask

  // Waits until every byte is taken and every descriptor has arrived.
  task automatic wait_drained();
    int unsigned guard;
    guard = 0;
    while ((accepted_count != pushed_count || expected_writes.size() != 0) &&
           guard < DRAIN_GUARD) begin
      @(negedge clk);
      guard++;
    end
    if (accepted_count != pushed_count)
      report_mismatch("input stalled, words taken", accepted_count, pushed_count);
    if (expected_writes.size() != 0) begin
      report_mismatch("descriptors never arrived", expected_writes.size(), 32'd0);
      expected_writes.delete();
    end
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_register(input logic [2:0] idx, input logic [14:0] value,
                                input bit last_one);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    if (last_one) begin
      @(negedge clk);
      cfg_wr_en <= 1'b0;
    end
  endtask

  task automatic configure(input int unsigned w, input int unsigned h, input bit col,
                           input bit revx, input bit bup);
    write_register(CFG_IMAGE_WIDTH, 15'(w), 1'b0);
    write_register(CFG_IMAGE_HEIGHT, 15'(h), 1'b0);
    write_register(CFG_COLUMN_ORDER, {14'd0, col}, 1'b0);
    write_register(CFG_REVERSE_X, {14'd0, revx}, 1'b0);
    write_register(CFG_BOTTOM_UP, {14'd0, bup}, 1'b1);
  endtask

  // One channel of an adaptive RLE line: runs, literals, zero counts and clips.
  task automatic gen_channel(input int unsigned len);
    int unsigned left, cnt, k, n;
    left = len;
    while (left > 0) begin
      k = $urandom_range(0, 9);
      if (k < 4) begin
        if (k == 0 && left < 127) cnt = $urandom_range(left + 1, 127);
        else cnt = $urandom_range(1, (left < 127) ? left : 127);
        push_byte(8'(RUN_THRESHOLD | cnt), 1'b1);
        push_random(1);
        left -= (cnt < left) ? cnt : left;
      end else if (k < 8) begin
        n = $urandom_range(1, (left < 6) ? left : 6);
        push_byte(8'(n), 1'b1);
        push_random(n);
        left -= n;
      end else if (k == 8 && left < 128) begin
        // Literal count past the line end: only the bytes that fit follow.
        n = $urandom_range(left + 1, 128);
        push_byte(8'(n), 1'b1);
        push_random(left);
        left = 0;
      end else begin
        push_byte(8'd0, 1'b1);
      end
    end
  endtask

  task automatic gen_rle_line(input int unsigned len);
    push_byte(HDR_MARK, 1'b1);
    push_byte(HDR_MARK, 1'b1);
    push_byte(8'(len >> 8), 1'b1);
    push_byte(8'(len), 1'b1);
    repeat (4) gen_channel(len);
  endtask

  // Old RLE line; a broken header opens it as a plain texel when asked.
  task automatic gen_old_line(input int unsigned len, input bit broken);
    int unsigned     left, shift, k, e;
    longint unsigned cnt;
    left = len;
    shift = 0;
    if (broken) begin
      push_byte(HDR_MARK, 1'b1);
      push_byte(HDR_MARK, 1'b1);
      if (len < MIN_RLE_LENGTH) begin
        push_byte(8'(len >> 8), 1'b1);
        push_byte(8'(len), 1'b1);
      end else if ($urandom_range(0, 1) == 1) begin
        push_byte(8'(len >> 8) | 8'h80, 1'b1);
        push_byte(8'(len), 1'b1);
      end else begin
        push_byte(8'(len >> 8), 1'b1);
        push_byte(8'(len + $urandom_range(1, 5)), 1'b1);
      end
      left--;
    end
    while (left > 0) begin
      k = $urandom_range(0, 9);
      if (k < 4) begin
        e = (k == 0) ? $urandom_range(0, 255) : $urandom_range(0, 6);
        push_byte(OLD_REP_MARK, 1'b1);
        push_byte(OLD_REP_MARK, 1'b1);
        push_byte(OLD_REP_MARK, 1'b1);
        push_byte(8'(e), 1'b1);
        cnt = 64'(e) << shift;
        if (shift < SHIFT_MAX) shift += SHIFT_STEP;
        if (cnt >= left) left = 0;
        else left -= int'(cnt);
      end else begin
        push_random(4);
        shift = 0;
        left--;
      end
    end
  endtask

  // One random image: geometry, line mix, and optional pressure.
  task automatic random_phase(input bit hold_off);
    int unsigned len, lines, k, t, i;
    bit          col;
    k = $urandom_range(0, 15);
    if (k < 2) len = $urandom_range(1, 7);
    else if (k < 12) len = $urandom_range(8, 24);
    else if (k < 15) len = $urandom_range(25, 64);
    else len = $urandom_range(65, 300);
    lines = $urandom_range(1, (len > 64) ? 1 : 5);
    col = 1'($urandom_range(0, 1));
    sender_idling = ($urandom_range(0, 3) != 0);
    receiver_idling = ($urandom_range(0, 3) != 0);
    if (col) configure(lines, len, col, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    else configure(len, lines, col, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    if (!hold_off && $urandom_range(0, 9) == 0) begin
      // Noise under this geometry.
      push_random(24);
    end else begin
      if (hold_off) long_hold_req = 1'b1;
      for (i = 0; i < lines; i++) begin
        if (i == 1 && !pause_done) begin
          pause_done = 1'b1;
          wait_drained();
        end
        t = $urandom_range(0, 9);
        if (len >= MIN_RLE_LENGTH && t < 6) gen_rle_line(len);
        else gen_old_line(len, t == 9);
      end
      // A few words after the last scanline, which are dropped.
      if ($urandom_range(0, 4) == 0)
        repeat (3) push_byte(8'($urandom_range(0, 255)), 1'b0);
    end
    wait_drained();
  endtask

  // Main sequence.
  initial begin
    int unsigned phase_no;
    int unsigned idx;
    reg_width = 15'd1;
    reg_height = 15'd1;
    reg_col = 1'b0;
    reg_revx = 1'b0;
    reg_bup = 1'b0;
    clear_scan_state();
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    repeat (4) @(negedge clk);

    // Directed image, 8 by 2, mirrored in x.
    configure(8, 2, 1'b0, 1'b1, 1'b0);
    // Adaptive line: run, zero control, clipped run, run, run, literal clipped at line end.
    push_byte(HDR_MARK, 1'b1);
    push_byte(HDR_MARK, 1'b1);
    push_byte(8'd0, 1'b1);
    push_byte(8'd8, 1'b1);
    push_byte(8'h88, 1'b1);
    push_byte(8'hAB, 1'b1);
    push_byte(8'h00, 1'b1);
    push_byte(8'hC8, 1'b1);
    push_byte(8'hFF, 1'b1);
    push_byte(8'h88, 1'b1);
    push_byte(8'h00, 1'b1);
    push_byte(8'h86, 1'b1);
    push_byte(8'h55, 1'b1);
    push_byte(8'h05, 1'b1);
    push_byte(8'hFF, 1'b1);
    push_byte(8'h01, 1'b1);
    // Old line: repeat at line start, literal texel, repeat clipped at line end.
    push_byte(OLD_REP_MARK, 1'b1);
    push_byte(OLD_REP_MARK, 1'b1);
    push_byte(OLD_REP_MARK, 1'b1);
    push_byte(8'd5, 1'b1);
    push_byte(8'hFF, 1'b1);
    push_byte(8'h00, 1'b1);
    push_byte(8'h80, 1'b1);
    push_byte(8'h7F, 1'b1);
    push_byte(OLD_REP_MARK, 1'b1);
    push_byte(OLD_REP_MARK, 1'b1);
    push_byte(OLD_REP_MARK, 1'b1);
    push_byte(8'd3, 1'b1);
    wait_drained();

    // Unused register indexes must not restart a finished image.
    for (idx = CFG_BOTTOM_UP + 1; idx <= 7; idx++)
      write_register(3'(idx), 15'($urandom_range(0, 32767)), idx == 7);
    repeat (4) push_byte(8'($urandom_range(0, 255)), 1'b0);
    wait_drained();

    // Widest rows, both mirrors; second line is one run of the whole line.
    configure(32767, 2, 1'b0, 1'b1, 1'b1);
    push_random(4);
    repeat (2) begin
      push_byte(OLD_REP_MARK, 1'b1);
      push_byte(OLD_REP_MARK, 1'b1);
      push_byte(OLD_REP_MARK, 1'b1);
      push_byte(8'hFF, 1'b1);
    end
    push_byte(OLD_REP_MARK, 1'b1);
    push_byte(OLD_REP_MARK, 1'b1);
    push_byte(OLD_REP_MARK, 1'b1);
    push_byte(8'h00, 1'b1);
    push_byte(OLD_REP_MARK, 1'b1);
    push_byte(OLD_REP_MARK, 1'b1);
    push_byte(OLD_REP_MARK, 1'b1);
    push_byte(8'hFF, 1'b1);
    wait_drained();

    // Largest image as columns: full-length header, long run, literal of 128.
    configure(32767, 32767, 1'b1, 1'b1, 1'b1);
    push_byte(HDR_MARK, 1'b1);
    push_byte(HDR_MARK, 1'b1);
    push_byte(8'h7F, 1'b1);
    push_byte(8'hFF, 1'b1);
    push_byte(8'hFF, 1'b1);
    push_random(1);
    push_byte(RUN_THRESHOLD, 1'b1);
    push_random(3);
    wait_drained();

    // Zero dimensions act as one texel; a short header is just a texel.
    configure(0, 0, 1'b0, 1'b0, 1'b0);
    push_byte(HDR_MARK, 1'b1);
    push_byte(HDR_MARK, 1'b1);
    push_byte(8'd0, 1'b1);
    push_byte(8'd1, 1'b1);
    repeat (4) push_byte(8'($urandom_range(0, 255)), 1'b0);
    wait_drained();

    // Random images until the word budget is spent; the tail runs without idling.
    phase_no = 0;
    while (stim_total < STIM_BYTES) begin
      if (stim_total >= QUIET_FROM) quiet = 1'b1;
      random_phase(phase_no == 2);
      phase_no++;
    end

    quiet = 1'b1;
    wait_drained();
    repeat (10) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #3_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/rsrd_pkg.sv
rtl/rsrd_decode.sv
rtl/rsrd_addr.sv
rtl/rgbe_scanline_rle_decoder.sv
sim/rgbe_scanline_rle_decoder_test.sv
